[rtl/core/mvhfe_pkg.sv]
// Shared types, start codes and decode functions for the MPEG-2 video header field extractor.
package mvhfe_pkg;

    localparam logic [31:0] CODE_SEQ      = 32'h0000_01b3;
    localparam logic [31:0] CODE_EXT      = 32'h0000_01b5;
    localparam logic [31:0] CODE_GOP      = 32'h0000_01b8;
    localparam logic [31:0] CODE_PIC      = 32'h0000_0100;
    localparam logic [31:0] CODE_SLICE_LO = 32'h0000_0101;
    localparam logic [31:0] CODE_SLICE_HI = 32'h0000_01af;
    localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

    localparam int NUM_FIELDS = 30;
    localparam int ID_W       = 5;
    localparam int VAL_W      = 32;
    localparam logic [ID_W-1:0] LAST_ID = ID_W'(NUM_FIELDS - 1);

    localparam logic [3:0] EXT_SEQ  = 4'd1;
    localparam logic [3:0] EXT_DISP = 4'd2;
    localparam logic [3:0] EXT_PIC  = 4'd8;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_SEQ  = 3'd1,
        KIND_EXT  = 3'd2,
        KIND_GOP  = 3'd3,
        KIND_PIC  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [5:0]  pres;
        logic [13:0] hsize;
        logic [13:0] vsize;
        logic [13:0] dhsize;
        logic [13:0] dvsize;
        logic [31:0] rnum;
        logic [31:0] rden;
        logic [29:0] brate;
        logic [2:0]  aspect;
        logic        lowdelay;
        logic [7:0]  profile;
        logic        prog;
        logic [9:0]  chroma;
        logic [2:0]  vfmt;
        logic [7:0]  prim;
        logic [7:0]  transfer;
        logic [7:0]  matrix;
        logic        closed;
        logic        tff;
        logic [9:0]  tref;
        logic [1:0]  ftype;
        logic [31:0] vbv;
    } fld_t;

    function automatic logic [31:0] rate_num(input logic [3:0] c);
        logic [31:0] r;
        case (c)
            4'd1:    r = 32'd24000;
            4'd2:    r = 32'd24;
            4'd3:    r = 32'd25;
            4'd4:    r = 32'd30000;
            4'd5:    r = 32'd30;
            4'd6:    r = 32'd50;
            4'd7:    r = 32'd60000;
            4'd8:    r = 32'd60;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rate_den(input logic [3:0] c);
        logic [31:0] r;
        case (c)
            4'd1, 4'd4, 4'd7:             r = 32'd1001;
            4'd2, 4'd3, 4'd5, 4'd6, 4'd8: r = 32'd1;
            default:                      r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] needed_bytes(input kind_t k, input logic [7:0] b0);
        logic [3:0] n;
        n = 4'd1;
        unique case (k)
            KIND_SEQ: n = 4'd7;
            KIND_GOP: n = 4'd4;
            KIND_PIC: n = 4'd4;
            KIND_EXT:
            begin
                case (b0[7:4])
                    EXT_SEQ:  n = 4'd6;
                    EXT_DISP: n = 4'd8;
                    EXT_PIC:  n = 4'd4;
                    default:  n = 4'd1;
                endcase
            end
            default: n = 4'd1;
        endcase
        return n;
    endfunction

    // The header word holds the first captured byte in its top bits.
    function automatic fld_t decode(input fld_t f, input kind_t k, input logic [63:0] w);
        fld_t        r;
        logic [2:0]  pt;
        logic [34:0] pn;
        logic [37:0] pd;
        r  = f;
        pn = f.rnum * ({1'b0, w[22:21]} + 3'd1);
        pd = f.rden * ({1'b0, w[20:16]} + 6'd1);
        pt = w[53:51];
        unique case (k)
            KIND_SEQ:
            begin
                r.pres[0] = 1'b1;
                r.hsize   = {2'b0, w[63:52]};
                r.vsize   = {2'b0, w[51:40]};
                r.aspect  = (w[39:36] >= 4'd2 && w[39:36] <= 4'd4) ? w[38:36] : 3'd0;
                r.rnum    = rate_num(w[35:32]);
                r.rden    = rate_den(w[35:32]);
                r.brate   = {12'b0, w[31:14]};
            end
            KIND_EXT:
            begin
                case (w[63:60])
                    EXT_SEQ:
                    begin
                        r.pres[1]      = 1'b1;
                        r.hsize[13:12] = f.hsize[13:12] | w[48:47];
                        r.vsize[13:12] = f.vsize[13:12] | w[46:45];
                        r.brate[29:18] = f.brate[29:18] | w[44:33];
                        r.lowdelay     = w[23];
                        if (f.rnum != 32'd0)
                        begin
                            r.rnum = (pn[34:32] != 3'd0) ? ALL_ONES : pn[31:0];
                            r.rden = (pd[37:32] != 6'd0) ? ALL_ONES : pd[31:0];
                        end
                        r.profile = w[59:52];
                        r.prog    = w[51];
                        case (w[50:49])
                            2'd1:    r.chroma = 10'd420;
                            2'd2:    r.chroma = 10'd422;
                            2'd3:    r.chroma = 10'd444;
                            default: r.chroma = 10'd0;
                        endcase
                    end
                    EXT_DISP:
                    begin
                        r.pres[2] = 1'b1;
                        r.vfmt    = w[59:57];
                        if (w[56])
                        begin
                            r.pres[4]  = 1'b1;
                            r.prim     = w[55:48];
                            r.transfer = w[47:40];
                            r.matrix   = w[39:32];
                        end
                        r.dhsize = w[31:18];
                        r.dvsize = w[16:3];
                    end
                    EXT_PIC:
                    begin
                        r.pres[3] = 1'b1;
                        r.tff     = w[39];
                    end
                    default: r = f;
                endcase
            end
            KIND_GOP:
            begin
                r.pres[5] = 1'b1;
                r.closed  = w[38];
            end
            KIND_PIC:
            begin
                r.tref  = w[63:54];
                r.ftype = (pt >= 3'd1 && pt <= 3'd3) ? pt[1:0] : 2'd0;
                r.vbv   = {16'b0, w[50:35]};
            end
            default: r = f;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/mvhfe_parser.sv]
// Start code search, header capture and field decode, one byte per cycle while byte_en is high.
module mvhfe_parser
    import mvhfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output fld_t       fields
);

    logic [31:0] win_reg, win_next;
    kind_t       kind_reg, kind_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        slice_reg, slice_next;
    logic [7:0]  hbuf_reg [8];
    logic [7:0]  hbuf_next [8];
    fld_t        fld_reg, fld_next;

    logic [7:0]  b [8];
    logic [3:0]  cnt_a;
    logic        is_hdr, is_slice, dec_main, en_main;
    kind_t       new_kind, kind_after, mkind;
    logic [63:0] w;
    fld_t        f1, f2;

    always_comb
    begin
        win_next   = win_reg;
        b          = hbuf_reg;
        cnt_a      = cnt_reg;
        is_hdr     = 1'b0;
        is_slice   = 1'b0;
        dec_main   = 1'b0;
        new_kind   = KIND_NONE;
        if (!slice_reg)
        begin
            win_next = {win_reg[23:0], data_byte};
            if (kind_reg != KIND_NONE)
            begin
                if (cnt_reg < 4'd8)
                    b[cnt_reg[2:0]] = data_byte;
                cnt_a = cnt_reg + 4'd1;
                if (cnt_a >= needed_bytes(kind_reg, b[0]))
                    dec_main = 1'b1;
            end
            is_hdr = win_next == CODE_SEQ || win_next == CODE_EXT ||
                     win_next == CODE_GOP || win_next == CODE_PIC;
            is_slice = win_next >= CODE_SLICE_LO && win_next <= CODE_SLICE_HI;
            if ((is_hdr || is_slice) && kind_reg != KIND_NONE)
                dec_main = 1'b1;
            new_kind = (win_next == CODE_SEQ) ? KIND_SEQ :
                       (win_next == CODE_EXT) ? KIND_EXT :
                       (win_next == CODE_GOP) ? KIND_GOP : KIND_PIC;
        end
        kind_after = is_hdr ? new_kind : (dec_main ? KIND_NONE : kind_reg);
        en_main    = dec_main || (last_byte && kind_after != KIND_NONE && !is_hdr);
        mkind      = dec_main ? kind_reg : kind_after;
        w          = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
        f1         = en_main ? decode(fld_reg, mkind, w) : fld_reg;
        f2         = (last_byte && is_hdr) ? decode(f1, new_kind, 64'd0) : f1;
        fields     = f2;

        slice_next = slice_reg | is_slice;
        kind_next  = kind_after;
        cnt_next   = (is_hdr || dec_main) ? 4'd0 : cnt_a;
        hbuf_next  = b;
        if (is_hdr)
            hbuf_next = '{default: 8'd0};
        fld_next = f2;
        if (last_byte)
        begin
            win_next      = ALL_ONES;
            kind_next     = KIND_NONE;
            cnt_next      = 4'd0;
            slice_next    = 1'b0;
            hbuf_next     = '{default: 8'd0};
            fld_next.pres  = 6'd0;
            fld_next.ftype = 2'd0;
            fld_next.tref  = 10'd0;
            fld_next.tff   = 1'b0;
            fld_next.vbv   = ALL_ONES;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= ALL_ONES;
            kind_reg  <= KIND_NONE;
            cnt_reg   <= 4'd0;
            slice_reg <= 1'b0;
            hbuf_reg  <= '{default: 8'd0};
            fld_reg   <= fld_t'({{($bits(fld_t) - 32){1'b0}}, ALL_ONES});
        end
        else if (byte_en)
        begin
            win_reg   <= win_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            slice_reg <= slice_next;
            hbuf_reg  <= hbuf_next;
            fld_reg   <= fld_next;
        end
    end

endmodule

[rtl/core/mvhfe_report.sv]
// Report register bank and the record serializer for one frame.
module mvhfe_report
    import mvhfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fld_t              fields,
    output logic              busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ID_W-1:0]   field_id,
    output logic [VAL_W-1:0]  field_value,
    output logic              last_field
);

    logic [VAL_W-1:0] rpt_reg [NUM_FIELDS];
    logic [VAL_W-1:0] vals [NUM_FIELDS];
    logic [ID_W-1:0]  idx_reg;
    logic             busy_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            vals[i] = {31'd0, fields.pres[i]};
        vals[6]  = {18'd0, fields.hsize};
        vals[7]  = {18'd0, fields.vsize};
        vals[8]  = {31'd0, fields.aspect != 3'd0};
        case (fields.aspect)
            3'd2:    begin vals[9] = 32'd4;   vals[10] = 32'd3;   end
            3'd3:    begin vals[9] = 32'd16;  vals[10] = 32'd9;   end
            3'd4:    begin vals[9] = 32'd221; vals[10] = 32'd100; end
            default: begin vals[9] = 32'd0;   vals[10] = 32'd0;   end
        endcase
        vals[11] = {31'd0, fields.rnum != 32'd0};
        vals[12] = fields.rnum;
        vals[13] = fields.rden;
        vals[14] = {2'd0, fields.brate};
        vals[15] = {31'd0, fields.lowdelay};
        vals[16] = {24'd0, fields.profile};
        vals[17] = {31'd0, fields.prog};
        vals[18] = {22'd0, fields.chroma};
        vals[19] = {29'd0, fields.vfmt};
        vals[20] = {24'd0, fields.prim};
        vals[21] = {24'd0, fields.transfer};
        vals[22] = {24'd0, fields.matrix};
        vals[23] = {18'd0, fields.dhsize};
        vals[24] = {18'd0, fields.dvsize};
        vals[25] = {31'd0, fields.closed};
        vals[26] = {31'd0, fields.tff};
        vals[27] = {22'd0, fields.tref};
        vals[28] = {30'd0, fields.ftype};
        vals[29] = fields.vbv;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rpt_reg <= vals;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (idx_reg == LAST_ID)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    assign busy        = busy_reg;
    assign m_tvalid    = busy_reg;
    assign field_id    = idx_reg;
    assign field_value = rpt_reg[idx_reg];
    assign last_field  = idx_reg == LAST_ID;

endmodule

[rtl/core/mpeg2_video_header_field_extractor.sv]
// Top level of the MPEG-2 video header field extractor.
//
//  Channel   Dir  tdata (low bit up)                     tlast
//  s_axis    in   data_byte[7:0]                         last_byte
//  m_axis    out  field_id[4:0], field_value[36:5], 0s   last_field
//
// A byte is parsed in the cycle it is accepted, one byte per clock while s_tready is high.
// The last byte of a frame loads a 30-item report, which appears on the output the next
// cycle and drains one item per cycle from the report registers while m_tready is high.
// Bytes keep flowing while a report drains; only a last byte waits until it has drained.
// Reset clears all header state; output stalls freeze the report counter.
module mpeg2_video_header_field_extractor
    import mvhfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // field_id, field_value, zero pad
    output logic        m_tlast
);

    logic             accept;
    logic             busy;
    fld_t             fields;
    logic [ID_W-1:0]  field_id;
    logic [VAL_W-1:0] field_value;

    assign s_tready = !(busy && s_tlast);
    assign accept   = s_tvalid && s_tready;

    mvhfe_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .fields    (fields)
    );

    mvhfe_report u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && s_tlast),
        .fields      (fields),
        .busy        (busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .field_id    (field_id),
        .field_value (field_value),
        .last_field  (m_tlast)
    );

    assign m_tdata = {3'b000, field_value, field_id};

endmodule

[rtl/core/mvhfe_checker.sv]
// Port-level assertions for the header field extractor, bound to the top level.
module mvhfe_checker
    import mvhfe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    a_last_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[4:0] == LAST_ID)))
        else $error("tlast does not match the final record id");

    a_last_held_during_report: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && s_tvalid && s_tlast) |-> !s_tready)
        else $error("final byte accepted while a report drains");

    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && m_tdata[4:0] == '0))
        else $error("report did not start at record zero");

    a_id_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1))
        else $error("record ids are not consecutive");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output valid after the final record");

endmodule

bind mpeg2_video_header_field_extractor mvhfe_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
